[rtl/core/cmr_pkg.sv]
// Shared types for the complex modulus replace unit.
// No dependencies; imported by every module of the block but the checker.
package cmr_pkg;

    // Side-band that travels with each beat down the pipeline
    typedef struct packed {
        logic valid;
        logic last;
        logic neg_re;
        logic neg_im;
    } cmr_ctl_t;

endpackage

[rtl/core/complex_modulus_replace_unit.sv]
// Complex modulus replace: rescales each complex sample to the target magnitude,
// keeping its phase. Takes one beat per clock and gives one beat per clock while
// the output is not stalled; the front end, the bit-per-stage square root and
// divider, and the output register lie between input and output.
// A stalled output holds one beat in a skid entry; in_stall rises only then.
module complex_modulus_replace_unit #(
    parameter int PART_BITS      = 16,
    parameter int NORM_FRAC_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [PART_BITS-1:0]   in_re,
    input  logic signed [PART_BITS-1:0]   in_im,
    input  logic [PART_BITS-1:0]          target_mag,
    input  logic                          last_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [PART_BITS:0]     out_re,
    output logic signed [PART_BITS:0]     out_im,
    output logic                          last_out
);
    import cmr_pkg::*;

    localparam int PW   = 2 * PART_BITS;
    localparam int NW   = PART_BITS + NORM_FRAC_BITS;
    localparam int NUMW = 2 * PART_BITS + NORM_FRAC_BITS;

    logic            en;
    cmr_ctl_t        ctl_f, ctl_s, ctl_d;
    logic [PW-1:0]   sumsq, pre_f, pim_f, pre_s, pim_s;
    logic [NW-1:0]   norm;
    logic [NUMW-1:0] q_re, q_im;

    assign in_stall = !en;

    cmr_front #(.PART_BITS(PART_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
        .in_re(in_re), .in_im(in_im), .target_mag(target_mag), .last_in(last_in),
        .ctl_o(ctl_f), .sumsq_o(sumsq), .prod_re_o(pre_f), .prod_im_o(pim_f)
    );

    cmr_isqrt #(.PART_BITS(PART_BITS), .NORM_FRAC_BITS(NORM_FRAC_BITS)) u_isqrt (
        .clk(clk), .rst_n(rst_n), .en(en), .ctl_i(ctl_f), .sumsq_i(sumsq),
        .prod_re_i(pre_f), .prod_im_i(pim_f),
        .ctl_o(ctl_s), .norm_o(norm), .prod_re_o(pre_s), .prod_im_o(pim_s)
    );

    cmr_div #(.PART_BITS(PART_BITS), .NORM_FRAC_BITS(NORM_FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .ctl_i(ctl_s), .norm_i(norm),
        .prod_re_i(pre_s), .prod_im_i(pim_s),
        .ctl_o(ctl_d), .q_re_o(q_re), .q_im_o(q_im)
    );

    cmr_out #(.PART_BITS(PART_BITS), .NORM_FRAC_BITS(NORM_FRAC_BITS)) u_out (
        .clk(clk), .rst_n(rst_n), .ctl_i(ctl_d), .q_re_i(q_re), .q_im_i(q_im),
        .en(en), .out_valid(out_valid), .out_stall(out_stall),
        .out_re(out_re), .out_im(out_im), .last_out(last_out)
    );

endmodule

[rtl/core/cmr_front.sv]
// Front end: part magnitudes, squares, products with target, sum of squares.
// Three register stages. Depends on cmr_pkg.
module cmr_front #(
    parameter int PART_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [PART_BITS-1:0]     in_re,
    input  logic [PART_BITS-1:0]     in_im,
    input  logic [PART_BITS-1:0]     target_mag,
    input  logic                     last_in,
    output cmr_pkg::cmr_ctl_t        ctl_o,
    output logic [2*PART_BITS-1:0]   sumsq_o,
    output logic [2*PART_BITS-1:0]   prod_re_o,
    output logic [2*PART_BITS-1:0]   prod_im_o
);
    import cmr_pkg::*;

    localparam int PW = 2 * PART_BITS;

    cmr_ctl_t               ctl_a_reg, ctl_b_reg, ctl_c_reg;
    cmr_ctl_t               ctl_a_next;
    logic [PART_BITS-1:0]   mag_re_reg, mag_im_reg, tgt_reg;
    logic [PART_BITS-1:0]   mag_re_next, mag_im_next;
    logic [PW-1:0]          sq_re_reg, sq_im_reg, pre_b_reg, pim_b_reg;
    logic [PW-1:0]          sumsq_reg, pre_c_reg, pim_c_reg;

    always_comb
    begin
        ctl_a_next.valid  = in_valid;
        ctl_a_next.last   = last_in;
        ctl_a_next.neg_re = in_re[PART_BITS-1];
        ctl_a_next.neg_im = in_im[PART_BITS-1];
        mag_re_next = in_re[PART_BITS-1] ? (~in_re + 1'b1) : in_re;
        mag_im_next = in_im[PART_BITS-1] ? (~in_im + 1'b1) : in_im;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
        end
        else if (en)
        begin
            ctl_a_reg <= ctl_a_next;
            ctl_b_reg <= ctl_a_reg;
            ctl_c_reg <= ctl_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_re_reg <= mag_re_next;
            mag_im_reg <= mag_im_next;
            tgt_reg    <= target_mag;
            sq_re_reg  <= PW'(mag_re_reg) * PW'(mag_re_reg);
            sq_im_reg  <= PW'(mag_im_reg) * PW'(mag_im_reg);
            pre_b_reg  <= PW'(mag_re_reg) * PW'(tgt_reg);
            pim_b_reg  <= PW'(mag_im_reg) * PW'(tgt_reg);
            sumsq_reg  <= sq_re_reg + sq_im_reg;
            pre_c_reg  <= pre_b_reg;
            pim_c_reg  <= pim_b_reg;
        end
    end

    assign ctl_o     = ctl_c_reg;
    assign sumsq_o   = sumsq_reg;
    assign prod_re_o = pre_c_reg;
    assign prod_im_o = pim_c_reg;

endmodule

[rtl/core/cmr_isqrt.sv]
// Pipelined integer square root of sumsq scaled by 2^(2*NORM_FRAC_BITS).
// One root bit per stage; products ride alongside. Depends on cmr_pkg.
module cmr_isqrt #(
    parameter int PART_BITS      = 16,
    parameter int NORM_FRAC_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  cmr_pkg::cmr_ctl_t                   ctl_i,
    input  logic [2*PART_BITS-1:0]              sumsq_i,
    input  logic [2*PART_BITS-1:0]              prod_re_i,
    input  logic [2*PART_BITS-1:0]              prod_im_i,
    output cmr_pkg::cmr_ctl_t                   ctl_o,
    output logic [PART_BITS+NORM_FRAC_BITS-1:0] norm_o,
    output logic [2*PART_BITS-1:0]              prod_re_o,
    output logic [2*PART_BITS-1:0]              prod_im_o
);
    import cmr_pkg::*;

    localparam int PW   = 2 * PART_BITS;
    localparam int NW   = PART_BITS + NORM_FRAC_BITS;
    localparam int RADW = 2 * NW;
    localparam int RW   = NW + 3;

    cmr_ctl_t          ctl_reg  [NW];
    logic [RW-1:0]     rem_reg  [NW];
    logic [NW-1:0]     root_reg [NW];
    logic [RADW-1:0]   rad_reg  [NW];
    logic [PW-1:0]     pre_reg  [NW];
    logic [PW-1:0]     pim_reg  [NW];

    for (genvar i = 0; i < NW; i++)
    begin : g_stage
        cmr_ctl_t          ctl_in;
        logic [RW-1:0]     rem_in, cur, trial;
        logic [NW-1:0]     root_in;
        logic [RADW-1:0]   rad_in;
        logic [PW-1:0]     pre_in, pim_in;
        logic              ge;

        if (i == 0)
        begin : g_first
            assign ctl_in  = ctl_i;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = RADW'(sumsq_i) << (2 * NORM_FRAC_BITS);
            assign pre_in  = prod_re_i;
            assign pim_in  = prod_im_i;
        end
        else
        begin : g_next
            assign ctl_in  = ctl_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign rad_in  = rad_reg[i-1];
            assign pre_in  = pre_reg[i-1];
            assign pim_in  = pim_reg[i-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign cur   = {rem_in[RW-3:0], rad_in[RADW-1 -: 2]};
        assign trial = RW'({root_in, 2'b01});
        assign ge    = (cur >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[i] <= '0;
            else if (en)
                ctl_reg[i] <= ctl_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? (cur - trial) : cur;
                root_reg[i] <= {root_in[NW-2:0], ge};
                rad_reg[i]  <= rad_in << 2;
                pre_reg[i]  <= pre_in;
                pim_reg[i]  <= pim_in;
            end
        end
    end

    assign ctl_o     = ctl_reg[NW-1];
    assign norm_o    = root_reg[NW-1];
    assign prod_re_o = pre_reg[NW-1];
    assign prod_im_o = pim_reg[NW-1];

endmodule

[rtl/core/cmr_div.sv]
// Pipelined restoring divider, two lanes sharing one divisor (the norm).
// One quotient bit per stage. Depends on cmr_pkg.
module cmr_div #(
    parameter int PART_BITS      = 16,
    parameter int NORM_FRAC_BITS = 8
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          en,
    input  cmr_pkg::cmr_ctl_t                             ctl_i,
    input  logic [PART_BITS+NORM_FRAC_BITS-1:0]           norm_i,
    input  logic [2*PART_BITS-1:0]                        prod_re_i,
    input  logic [2*PART_BITS-1:0]                        prod_im_i,
    output cmr_pkg::cmr_ctl_t                             ctl_o,
    output logic [2*PART_BITS+NORM_FRAC_BITS-1:0]         q_re_o,
    output logic [2*PART_BITS+NORM_FRAC_BITS-1:0]         q_im_o
);
    import cmr_pkg::*;

    localparam int NW   = PART_BITS + NORM_FRAC_BITS;
    localparam int NUMW = 2 * PART_BITS + NORM_FRAC_BITS;

    cmr_ctl_t          ctl_reg [NUMW];
    logic [NW-1:0]     d_reg   [NUMW];
    logic [NW-1:0]     rem_reg [NUMW][2];
    logic [NUMW-1:0]   num_reg [NUMW][2];
    logic [NUMW-1:0]   q_reg   [NUMW][2];

    logic [NW-1:0]     d_first;
    logic [NUMW-1:0]   num_first [2];

    // a zero norm stands for one in the fixed-point scale
    assign d_first      = (norm_i == '0) ? (NW'(1) << NORM_FRAC_BITS) : norm_i;
    assign num_first[0] = NUMW'(prod_re_i) << NORM_FRAC_BITS;
    assign num_first[1] = NUMW'(prod_im_i) << NORM_FRAC_BITS;

    for (genvar s = 0; s < NUMW; s++)
    begin : g_stage
        cmr_ctl_t      ctl_in;
        logic [NW-1:0] d_in;

        if (s == 0)
        begin : g_first
            assign ctl_in = ctl_i;
            assign d_in   = d_first;
        end
        else
        begin : g_next
            assign ctl_in = ctl_reg[s-1];
            assign d_in   = d_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[s] <= '0;
            else if (en)
                ctl_reg[s] <= ctl_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                d_reg[s] <= d_in;
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [NW-1:0]   rem_in;
            logic [NUMW-1:0] num_in, q_in;
            logic [NW:0]     cur;
            logic            ge;

            if (s == 0)
            begin : g_first
                assign rem_in = '0;
                assign num_in = num_first[l];
                assign q_in   = '0;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[s-1][l];
                assign num_in = num_reg[s-1][l];
                assign q_in   = q_reg[s-1][l];
            end

            assign cur = {rem_in, num_in[NUMW-1]};
            assign ge  = (cur >= {1'b0, d_in});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s][l] <= ge ? NW'(cur - {1'b0, d_in}) : NW'(cur);
                    num_reg[s][l] <= num_in << 1;
                    q_reg[s][l]   <= {q_in[NUMW-2:0], ge};
                end
            end
        end
    end

    assign ctl_o  = ctl_reg[NUMW-1];
    assign q_re_o = q_reg[NUMW-1][0];
    assign q_im_o = q_reg[NUMW-1][1];

endmodule

[rtl/core/cmr_out.sv]
// Output stage: saturate, restore sign, output register with skid entry.
// Drives the pipeline advance enable. Depends on cmr_pkg.
module cmr_out #(
    parameter int PART_BITS      = 16,
    parameter int NORM_FRAC_BITS = 8
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  cmr_pkg::cmr_ctl_t                        ctl_i,
    input  logic [2*PART_BITS+NORM_FRAC_BITS-1:0]    q_re_i,
    input  logic [2*PART_BITS+NORM_FRAC_BITS-1:0]    q_im_i,
    output logic                                     en,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [PART_BITS:0]                out_re,
    output logic signed [PART_BITS:0]                out_im,
    output logic                                     last_out
);
    import cmr_pkg::*;

    localparam int NUMW = 2 * PART_BITS + NORM_FRAC_BITS;
    localparam int OW   = PART_BITS + 1;

    logic              out_valid_reg, skid_valid_reg;
    logic [OW-1:0]     ore_reg, oim_reg, sre_reg, sim_reg;
    logic              olast_reg, slast_reg;
    logic [OW-1:0]     re_next, im_next;
    logic              pipe_v, load_out;

    function automatic logic [OW-1:0] sat_sign(input logic [NUMW-1:0] q, input logic neg);
        logic [PART_BITS-1:0] m;
        begin
            m = (|q[NUMW-1:PART_BITS]) ? '1 : q[PART_BITS-1:0];
            sat_sign = neg ? (~{1'b0, m} + 1'b1) : {1'b0, m};
        end
    endfunction

    assign re_next  = sat_sign(q_re_i, ctl_i.neg_re);
    assign im_next  = sat_sign(q_im_i, ctl_i.neg_im);
    assign en       = !skid_valid_reg;
    assign pipe_v   = ctl_i.valid && en;
    assign load_out = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg  <= skid_valid_reg || pipe_v;
            skid_valid_reg <= 1'b0;
        end
        else if (pipe_v)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            // drain the skid entry first
            ore_reg   <= skid_valid_reg ? sre_reg : re_next;
            oim_reg   <= skid_valid_reg ? sim_reg : im_next;
            olast_reg <= skid_valid_reg ? slast_reg : ctl_i.last;
        end
        else if (pipe_v)
        begin
            sre_reg   <= re_next;
            sim_reg   <= im_next;
            slast_reg <= ctl_i.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_re    = ore_reg;
    assign out_im    = oim_reg;
    assign last_out  = olast_reg;

endmodule

[rtl/core/cmr_checker.sv]
// Port-level checks for complex_modulus_replace_unit, attached by bind.
// No dependencies beyond the top level's ports.
module cmr_checker #(
    parameter int PART_BITS = 16
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic signed [PART_BITS:0]   out_re,
    input logic signed [PART_BITS:0]   out_im,
    input logic                        last_out
);

    // a held output beat keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_re) && $stable(out_im)
            && $stable(last_out))
        else $error("output beat changed while stalled");

    // input back-pressure only while an output beat is waiting
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stall raised without output stall");

    // saturation never reaches the most negative code
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_re[PART_BITS] && out_re[PART_BITS-1:0] == '0)
            && !(out_im[PART_BITS] && out_im[PART_BITS-1:0] == '0))
        else $error("output part outside saturation range");

endmodule

bind complex_modulus_replace_unit cmr_checker #(.PART_BITS(PART_BITS)) u_cmr_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
    .out_stall(out_stall), .out_re(out_re), .out_im(out_im), .last_out(last_out)
);

[test/tb_complex_modulus_replace_unit.sv]
// Testbench for complex_modulus_replace_unit: directed and random samples, own predictor.
// Depends on the block's RTL only (cmr_pkg needs no import here).
`timescale 1ns / 1ps

module tb_complex_modulus_replace_unit;

    localparam int PART_BITS      = 16;
    localparam int NORM_FRAC_BITS = 8;
    localparam int N_RANDOM       = 1130;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct packed {
        logic signed [PART_BITS-1:0] re;
        logic signed [PART_BITS-1:0] im;
        logic [PART_BITS-1:0]        target;
        logic                        last;
    } sample_t;

    typedef struct packed {
        logic signed [PART_BITS:0] re;
        logic signed [PART_BITS:0] im;
        logic                      last;
    } scaled_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [PART_BITS-1:0] in_re;
    logic signed [PART_BITS-1:0] in_im;
    logic [PART_BITS-1:0] target_mag;
    logic last_in;
    logic out_valid;
    logic out_stall;
    logic signed [PART_BITS:0] out_re;
    logic signed [PART_BITS:0] out_im;
    logic last_out;

    sample_t pending_samples[$];
    scaled_t expected_scaled[$];
    int      mismatches;
    int      send_idle;
    int      recv_idle;
    bit      quiet;
    bit      in_taken;

    complex_modulus_replace_unit #(
        .PART_BITS(PART_BITS),
        .NORM_FRAC_BITS(NORM_FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_re(in_re),
        .in_im(in_im),
        .target_mag(target_mag),
        .last_in(last_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_re(out_re),
        .out_im(out_im),
        .last_out(last_out)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned res;
        longint unsigned bitval;
        res    = 0;
        bitval = 64'd1 << 62;
        while (bitval > x)
            bitval = bitval >> 2;
        while (bitval != 0)
        begin
            if (x >= res + bitval)
            begin
                x   = x - (res + bitval);
                res = (res >> 1) + bitval;
            end
            else
                res = res >> 1;
            bitval = bitval >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [PART_BITS:0] rescale_part(
        longint signed part, longint unsigned target, longint unsigned norm);
        longint unsigned mag;
        longint unsigned quot;
        longint unsigned limit;
        limit = (64'd1 << PART_BITS) - 1;
        mag   = (part < 0) ? longint'(-part) : longint'(part);
        quot  = ((mag * target) << NORM_FRAC_BITS) / norm;
        if (quot > limit)
            quot = limit;
        return (part < 0) ? -(PART_BITS+1)'(quot) : (PART_BITS+1)'(quot);
    endfunction

    function automatic scaled_t project_magnitude(sample_t s);
        scaled_t         r;
        longint signed   re;
        longint signed   im;
        longint unsigned sumsq;
        longint unsigned norm;
        re    = s.re;
        im    = s.im;
        sumsq = re * re + im * im;
        if (sumsq == 0)
            norm = 64'd1 << NORM_FRAC_BITS;
        else
            norm = root_floor(sumsq << (2 * NORM_FRAC_BITS));
        r.re   = rescale_part(re, s.target, norm);
        r.im   = rescale_part(im, s.target, norm);
        r.last = s.last;
        return r;
    endfunction

    // Driver: advance on a beat taken at the last rising edge or when idle, hold a stalled beat
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (send_idle > 0)
            begin
                send_idle <= send_idle - 1;
                in_valid  <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                send_idle <= $urandom_range(0, 7);
                in_valid  <= 1'b0;
            end
            else if (pending_samples.size() > 0)
            begin
                in_valid   <= 1'b1;
                in_re      <= pending_samples[0].re;
                in_im      <= pending_samples[0].im;
                target_mag <= pending_samples[0].target;
                last_in    <= pending_samples[0].last;
                void'(pending_samples.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
        if (rst_n)
        begin
            if (recv_idle > 0)
            begin
                recv_idle <= recv_idle - 1;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                recv_idle <= $urandom_range(0, 7);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Monitor: predict on each input beat, check each output beat
    always @(posedge clk)
    begin
        scaled_t want;
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            expected_scaled.push_back(project_magnitude({in_re, in_im, target_mag, last_in}));
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_scaled.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected beat re=%0d im=%0d last=%0b",
                             out_re, out_im, last_out);
            end
            else
            begin
                want = expected_scaled.pop_front();
                if (out_re !== want.re || out_im !== want.im || last_out !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: expected re=%0d im=%0d last=%0b, got re=%0d im=%0d last=%0b",
                                 want.re, want.im, want.last, out_re, out_im, last_out);
                end
            end
        end
    end

    initial
    begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        sample_t s;
        mismatches = 0;
        send_idle  = 0;
        recv_idle  = 0;
        quiet      = 1'b0;
        in_taken   = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_re      = '0;
        in_im      = '0;
        target_mag = '0;
        last_in    = 1'b0;
        out_stall  = 1'b0;

        // zero sample, zero target, extremes, saturation from tiny parts
        pending_samples.push_back({16'sd0, 16'sd0, 16'd0, 1'b0});
        pending_samples.push_back({16'sd0, 16'sd0, 16'hFFFF, 1'b1});
        pending_samples.push_back({16'sh8000, 16'sh8000, 16'hFFFF, 1'b0});
        pending_samples.push_back({16'sh7FFF, 16'sh7FFF, 16'hFFFF, 1'b1});
        pending_samples.push_back({16'sh8000, 16'sh7FFF, 16'd0, 1'b0});
        pending_samples.push_back({16'sh7FFF, 16'sh8000, 16'd1, 1'b0});
        pending_samples.push_back({16'sd1, 16'sd0, 16'hFFFF, 1'b0});
        pending_samples.push_back({16'sd0, -16'sd1, 16'hFFFF, 1'b1});
        pending_samples.push_back({16'sd1, -16'sd1, 16'hFFFF, 1'b0});
        pending_samples.push_back({16'sh8000, 16'sd0, 16'hFFFF, 1'b0});
        pending_samples.push_back({16'sd0, 16'sh8000, 16'd32768, 1'b0});
        pending_samples.push_back({16'sd3, 16'sd4, 16'd5, 1'b0});
        pending_samples.push_back({-16'sd3, 16'sd4, 16'd10, 1'b1});
        pending_samples.push_back({16'sd1, 16'sd1, 16'd1, 1'b0});
        pending_samples.push_back({16'sh7FFF, 16'sd0, 16'h7FFF, 1'b1});

        for (int i = 0; i < N_RANDOM; i++)
        begin
            s.re     = $urandom;
            s.im     = $urandom;
            s.target = $urandom;
            s.last   = $urandom_range(0, 1);
            // small parts now and then, to reach saturation and tiny norms
            if ($urandom_range(0, 3) == 0)
            begin
                s.re = $signed(16'($urandom_range(0, 15))) - 16'sd8;
                s.im = $signed(16'($urandom_range(0, 15))) - 16'sd8;
            end
            if ($urandom_range(0, 15) == 0)
                s.target = 0;
            pending_samples.push_back(s);
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_samples.size() < 150);
        quiet = 1'b1;
        wait (pending_samples.size() == 0);
        @(posedge clk);
        // hold until the final beat has been taken
        while (in_valid)
            @(posedge clk);
        wait (expected_scaled.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_scaled.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
